[src/source_byte_tokenizer_core_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the byte tokenizer
// Immediate-free concurrent assertion helpers; empty under synthesis.
// ---------------------------------------------------------------------------
`ifndef SOURCE_BYTE_TOKENIZER_CORE_MACROS_SVH
`define SOURCE_BYTE_TOKENIZER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define SBT_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define SBT_ASSERT_NEXT(label, clk, rstn, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) else $error(msg);
`else
`define SBT_ASSERT(label, clk, rstn, prop, msg)
`define SBT_ASSERT_NEXT(label, clk, rstn, pre, post, msg)
`endif
`endif

[src/sbt_pkg.sv]
// ---------------------------------------------------------------------------
// Byte tokenizer package
// Field widths, token kinds, scan modes and character class helpers.
// ---------------------------------------------------------------------------
package sbt_pkg;

  localparam int LenBits = 16;
  localparam int LocBits = 32;

  localparam logic [4:0] K_INVALID = 5'd0;
  localparam logic [4:0] K_EOF     = 5'd1;
  localparam logic [4:0] K_IDENT   = 5'd2;
  localparam logic [4:0] K_OPER    = 5'd3;
  localparam logic [4:0] K_INT     = 5'd4;
  localparam logic [4:0] K_FLOAT   = 5'd5;
  localparam logic [4:0] K_STRING  = 5'd6;
  localparam logic [4:0] K_CHAR    = 5'd7;
  localparam logic [4:0] K_ARROW   = 5'd8;
  localparam logic [4:0] K_ASSIGN  = 5'd9;
  localparam logic [4:0] K_DOT     = 5'd10;
  localparam logic [4:0] K_LBRACE  = 5'd11;
  localparam logic [4:0] K_RBRACE  = 5'd12;
  localparam logic [4:0] K_LBRACK  = 5'd13;
  localparam logic [4:0] K_RBRACK  = 5'd14;
  localparam logic [4:0] K_LPAREN  = 5'd15;
  localparam logic [4:0] K_RPAREN  = 5'd16;
  localparam logic [4:0] K_SEMI    = 5'd17;
  localparam logic [4:0] K_COLON   = 5'd18;
  localparam logic [4:0] K_COMMA   = 5'd19;

  localparam logic [1:0] RADIX_DEC = 2'd0;
  localparam logic [1:0] RADIX_HEX = 2'd1;
  localparam logic [1:0] RADIX_BIN = 2'd2;

  typedef enum logic [4:0] {
    M_IDLE, M_EOL, M_WS, M_SLASH, M_LINE, M_BLOCK, M_BSTAR, M_MINUS,
    M_EQ, M_DOT, M_DOTS, M_ZERO, M_NINT, M_FRAC, M_ESIGN, M_EXP,
    M_IDENT, M_OPER, M_STR, M_ESC
  } mode_e;

  typedef struct packed {
    logic [4:0]         kind;
    logic               line_start;
    logic               after_space;
    logic [LocBits-1:0] start;
    logic [LenBits-1:0] length;
    logic               last;
  } token_t;

  // One input beat: byte plus end mark
  typedef struct packed {
    logic [7:0] byte_value;
    logic       end_of_input;
  } in_beat_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_op(input logic [7:0] c);
    return c == "~" || c == "!" || c == "%" || c == "^" || c == "&" || c == "*" ||
           c == "-" || c == "+" || c == "=" || c == "|" || c == "<" || c == ">" ||
           c == "?" || c == "/";
  endfunction

  function automatic logic is_eol(input logic [7:0] c);
    return c == 8'h0d || c == 8'h0a;
  endfunction

endpackage

[src/sbt_in_if.sv]
// ---------------------------------------------------------------------------
// Input channel interface
// Valid/ready channel carrying one source byte beat.
// ---------------------------------------------------------------------------
interface sbt_in_if;
  logic                valid;
  logic                ready;
  logic [7:0]          byte_value;
  logic                end_of_input;
  modport source (output valid, output byte_value, output end_of_input, input ready);
  modport sink (input valid, input byte_value, input end_of_input, output ready);
endinterface

[src/sbt_out_if.sv]
// ---------------------------------------------------------------------------
// Token channel interface
// Valid/ready channel carrying one token beat.
// ---------------------------------------------------------------------------
interface sbt_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  token_kind;
  logic        at_line_start;
  logic        after_space;
  logic [31:0] start_location;
  logic [15:0] token_length;
  logic        last_of_step;
  modport source (output valid, output token_kind, output at_line_start,
                  output after_space, output start_location, output token_length,
                  output last_of_step, input ready);
  modport sink (input valid, input token_kind, input at_line_start,
                input after_space, input start_location, input token_length,
                input last_of_step, output ready);
endinterface

[src/sbt_scan.sv]
// ---------------------------------------------------------------------------
// Tokenizer scan step
// Combinational mode update for one beat; produces up to two tokens.
// ---------------------------------------------------------------------------
module sbt_scan (
  input  logic [4:0]          mode_i,
  input  logic [1:0]          pend_i,
  input  logic [1:0]          tflags_i,
  input  logic [31:0]         offset_i,
  input  logic [31:0]         tstart_i,
  input  logic [15:0]         count_i,
  input  logic [1:0]          radix_i,
  input  logic                quote_i,
  input  logic                lbb_i,
  input  logic [31:0]         base_i,
  input  sbt_pkg::in_beat_t   beat_i,
  output logic [4:0]          mode_o,
  output logic [1:0]          pend_o,
  output logic [1:0]          tflags_o,
  output logic [31:0]         offset_o,
  output logic [31:0]         tstart_o,
  output logic [15:0]         count_o,
  output logic [1:0]          radix_o,
  output logic                quote_o,
  output logic                lbb_o,
  output logic [1:0]          n_tok_o,
  output sbt_pkg::token_t     tok0_o,
  output sbt_pkg::token_t     tok1_o
);
  import sbt_pkg::*;

  mode_e      md;
  logic [1:0] pend, tfl, rdx, nt;
  logic [31:0] off, tst;
  logic [15:0] cnt;
  logic       qk, lbb, redo, done;
  logic [7:0] c;
  token_t     t0, t1;

  always_comb begin
    md = mode_e'(mode_i); pend = pend_i; tfl = tflags_i; off = offset_i;
    tst = tstart_i; cnt = count_i; rdx = radix_i; qk = quote_i; lbb = lbb_i;
    c = beat_i.byte_value; nt = 2'd0; t0 = '0; t1 = '0; redo = 1'b0; done = 1'b0;

    // Up to three passes: a close, a lookahead hop, then dispatch
    for (int pass = 0; pass < 3; pass++) begin
      if (!beat_i.end_of_input && !done) begin
        redo = 1'b0;
        // emit/take are written inline per mode
        case (md)
          M_IDLE: begin
            done = 1'b1;
            if (is_eol(c)) begin
              lbb = (c == 8'h0a); pend = 2'b11; md = M_EOL;
              off = off + 32'd1;
            end else if (c == " " || c == 8'h09) begin
              pend[1] = 1'b1; md = M_WS; off = off + 32'd1;
            end else begin
              tst = off; tfl = pend; cnt = 16'd1; off = off + 32'd1;
              if (c == 8'h22 || c == 8'h27) begin qk = (c == 8'h27); md = M_STR; end
              else if (c == "/") md = M_SLASH;
              else if (c == "-") md = M_MINUS;
              else if (c == "=") md = M_EQ;
              else if (c == ".") md = M_DOT;
              else if (c == "0") md = M_ZERO;
              else if (c == "@") md = M_IDENT;
              else if (is_digit(c)) begin rdx = RADIX_DEC; md = M_NINT; end
              else if (is_alpha(c)) md = M_IDENT;
              else if (is_op(c)) md = M_OPER;
              else begin
                case (c)
                  "{": t1.kind = K_LBRACE;
                  "}": t1.kind = K_RBRACE;
                  "[": t1.kind = K_LBRACK;
                  "]": t1.kind = K_RBRACK;
                  "(": t1.kind = K_LPAREN;
                  ")": t1.kind = K_RPAREN;
                  ";": t1.kind = K_SEMI;
                  ":": t1.kind = K_COLON;
                  ",": t1.kind = K_COMMA;
                  default: t1.kind = K_INVALID;
                endcase
                t1.line_start = tfl[0]; t1.after_space = tfl[1];
                t1.start = base_i + tst; t1.length = cnt;
                if (nt == 2'd0) t0 = t1;
                nt = nt + 2'd1; pend = 2'b00;
              end
            end
          end
          M_EOL: begin
            md = M_IDLE;
            if ((c ^ (lbb ? 8'h0a : 8'h0d)) == (8'h0d ^ 8'h0a)) begin
              off = off + 32'd1; done = 1'b1;
            end
          end
          M_WS: begin
            if (c == " " || c == 8'h09) begin off = off + 32'd1; done = 1'b1; end
            else md = M_IDLE;
          end
          M_SLASH: begin
            if (c == "/") begin off = off + 32'd1; md = M_LINE; done = 1'b1; end
            else if (c == "*") begin
              off = off + 32'd1; pend[1] = 1'b1; md = M_BLOCK; done = 1'b1;
            end else md = M_OPER;
          end
          M_LINE: begin
            if (is_eol(c)) md = M_IDLE;
            else begin off = off + 32'd1; done = 1'b1; end
          end
          M_BLOCK: begin
            off = off + 32'd1; done = 1'b1;
            if (c == "*") md = M_BSTAR;
          end
          M_BSTAR: begin
            off = off + 32'd1; done = 1'b1;
            if (c == "/") md = M_IDLE;
            else if (c != "*") md = M_BLOCK;
          end
          M_MINUS: begin
            if (c == ">") begin
              off = off + 32'd1; if (cnt != 16'hFFFF) cnt = cnt + 16'd1;
              t1.kind = K_ARROW; t1.line_start = tfl[0]; t1.after_space = tfl[1];
              t1.start = base_i + tst; t1.length = cnt;
              if (nt == 2'd0) t0 = t1;
              nt = nt + 2'd1; pend = 2'b00; md = M_IDLE; done = 1'b1;
            end else md = M_OPER;
          end
          M_EQ: begin
            if (is_op(c)) md = M_OPER;
            else begin t1.kind = K_ASSIGN; redo = 1'b1; end
          end
          M_DOT: begin
            if (c == ".") begin
              off = off + 32'd1; if (cnt != 16'hFFFF) cnt = cnt + 16'd1;
              md = M_DOTS; done = 1'b1;
            end else begin t1.kind = K_DOT; redo = 1'b1; end
          end
          M_DOTS: begin
            if (c == ".") begin
              off = off + 32'd1; if (cnt != 16'hFFFF) cnt = cnt + 16'd1; done = 1'b1;
            end else begin t1.kind = K_OPER; redo = 1'b1; end
          end
          M_ZERO: begin
            if (c == "x" || c == "X" || c == "b" || c == "B") begin
              off = off + 32'd1; if (cnt != 16'hFFFF) cnt = cnt + 16'd1;
              rdx = (c == "x" || c == "X") ? RADIX_HEX : RADIX_BIN;
              md = M_NINT; done = 1'b1;
            end else begin rdx = RADIX_DEC; md = M_NINT; end
          end
          M_NINT, M_FRAC, M_EXP: begin
            if (is_digit(c) || (rdx == RADIX_HEX &&
                ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")))) begin
              off = off + 32'd1; if (cnt != 16'hFFFF) cnt = cnt + 16'd1; done = 1'b1;
            end else if (md == M_NINT && c == ".") begin
              off = off + 32'd1; if (cnt != 16'hFFFF) cnt = cnt + 16'd1;
              md = M_FRAC; done = 1'b1;
            end else if (md != M_EXP &&
                ((rdx == RADIX_DEC && (c == "e" || c == "E")) ||
                 (rdx == RADIX_HEX && (c == "p" || c == "P")))) begin
              off = off + 32'd1; if (cnt != 16'hFFFF) cnt = cnt + 16'd1;
              md = M_ESIGN; done = 1'b1;
            end else begin
              t1.kind = (md == M_NINT) ? K_INT : K_FLOAT; redo = 1'b1;
            end
          end
          M_ESIGN: begin
            md = M_EXP;
            if (c == "+" || c == "-") begin
              off = off + 32'd1; if (cnt != 16'hFFFF) cnt = cnt + 16'd1; done = 1'b1;
            end
          end
          M_IDENT: begin
            if (is_alpha(c) || is_digit(c)) begin
              off = off + 32'd1; if (cnt != 16'hFFFF) cnt = cnt + 16'd1; done = 1'b1;
            end else begin t1.kind = K_IDENT; redo = 1'b1; end
          end
          M_OPER: begin
            if (is_op(c)) begin
              off = off + 32'd1; if (cnt != 16'hFFFF) cnt = cnt + 16'd1; done = 1'b1;
            end else begin t1.kind = K_OPER; redo = 1'b1; end
          end
          M_STR, M_ESC: begin
            if (md == M_STR && c == (qk ? 8'h27 : 8'h22)) begin
              off = off + 32'd1; if (cnt != 16'hFFFF) cnt = cnt + 16'd1;
              t1.kind = qk ? K_CHAR : K_STRING; t1.line_start = tfl[0];
              t1.after_space = tfl[1]; t1.start = base_i + tst; t1.length = cnt;
              if (nt == 2'd0) t0 = t1;
              nt = nt + 2'd1; pend = 2'b00; md = M_IDLE; done = 1'b1;
            end else if (is_eol(c)) begin
              t1.kind = qk ? K_CHAR : K_STRING; redo = 1'b1;
            end else begin
              off = off + 32'd1; if (cnt != 16'hFFFF) cnt = cnt + 16'd1; done = 1'b1;
              if (md == M_ESC) md = M_STR;
              else if (c == 8'h5c) md = M_ESC;
            end
          end
          default: md = M_IDLE;
        endcase
        // Close the open token and scan the byte again from idle
        if (redo) begin
          t1.line_start = tfl[0]; t1.after_space = tfl[1];
          t1.start = base_i + tst; t1.length = cnt;
          if (nt == 2'd0) t0 = t1;
          nt = nt + 2'd1; pend = 2'b00; md = M_IDLE;
        end
      end
    end

    // End mark: flush the open token, then emit end of file
    if (beat_i.end_of_input) begin
      t1.line_start = tfl[0]; t1.after_space = tfl[1];
      t1.start = base_i + tst; t1.length = cnt;
      case (md)
        M_SLASH, M_MINUS, M_OPER, M_DOTS: begin t1.kind = K_OPER; nt = 2'd1; end
        M_EQ: begin t1.kind = K_ASSIGN; nt = 2'd1; end
        M_DOT: begin t1.kind = K_DOT; nt = 2'd1; end
        M_ZERO, M_NINT: begin t1.kind = K_INT; nt = 2'd1; end
        M_FRAC, M_ESIGN, M_EXP: begin t1.kind = K_FLOAT; nt = 2'd1; end
        M_IDENT: begin t1.kind = K_IDENT; nt = 2'd1; end
        M_STR, M_ESC: begin t1.kind = qk ? K_CHAR : K_STRING; nt = 2'd1; end
        default: nt = 2'd0;
      endcase
      if (nt == 2'd1) begin
        t0 = t1; pend = 2'b00;
      end
      t1.kind = K_EOF; t1.line_start = pend[0]; t1.after_space = pend[1];
      t1.start = base_i + off; t1.length = '0;
      if (nt == 2'd0) t0 = t1;
      nt = nt + 2'd1;
      md = M_IDLE; pend = 2'b11; tfl = 2'b00; off = '0; tst = '0; cnt = '0;
      rdx = RADIX_DEC; qk = 1'b0; lbb = 1'b0;
    end

    if (nt == 2'd1) t0.last = 1'b1;
    else t1.last = 1'b1;
    mode_o = md; pend_o = pend; tflags_o = tfl; offset_o = off; tstart_o = tst;
    count_o = cnt; radix_o = rdx; quote_o = qk; lbb_o = lbb; n_tok_o = nt;
    tok0_o = t0; tok1_o = t1;
  end
endmodule

[src/source_byte_tokenizer_core.sv]
// A token is registered into the result buffer when the byte that closes it is accepted.
// Throughput: one byte per cycle while the output is ready; a byte closing two tokens
//   holds the input while the second token drains from the result buffer.
// Scan state and the buffer set by the two-entry token queue.
// Reset: async active low; scan state idle, flags set, base location zero.
// ---------------------------------------------------------------------------
// Byte tokenizer top level
// Scan state registers, scan step and two-entry token output buffer.
// ---------------------------------------------------------------------------
module source_byte_tokenizer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  sbt_in_if.sink      in_ch,
  sbt_out_if.source   out_ch
);
  import sbt_pkg::*;
  `include "source_byte_tokenizer_core_macros.svh"

  logic [31:0] base_q;
  logic [4:0]  mode_q, mode_d;
  logic [1:0]  pend_q, pend_d, tfl_q, tfl_d, rdx_q, rdx_d, nt;
  logic [31:0] off_q, off_d, tst_q, tst_d;
  logic [15:0] cnt_q, cnt_d;
  logic        qk_q, qk_d, lbb_q, lbb_d;
  token_t      tok0, tok1;
  token_t      buf_q [2];
  logic [1:0]  fill_q;
  logic        acc, pop;
  in_beat_t    beat;

  assign beat.byte_value   = in_ch.byte_value;
  assign beat.end_of_input = in_ch.end_of_input;

  sbt_scan u_scan (
    .mode_i(mode_q), .pend_i(pend_q), .tflags_i(tfl_q), .offset_i(off_q),
    .tstart_i(tst_q), .count_i(cnt_q), .radix_i(rdx_q), .quote_i(qk_q),
    .lbb_i(lbb_q), .base_i(base_q), .beat_i(beat),
    .mode_o(mode_d), .pend_o(pend_d), .tflags_o(tfl_d), .offset_o(off_d),
    .tstart_o(tst_d), .count_o(cnt_d), .radix_o(rdx_d), .quote_o(qk_d),
    .lbb_o(lbb_d), .n_tok_o(nt), .tok0_o(tok0), .tok1_o(tok1)
  );

  // Accept when the buffer has room for two tokens after this cycle's pop
  assign pop         = out_ch.valid && out_ch.ready;
  assign in_ch.ready = (fill_q == 2'd0) || (fill_q == 2'd1 && pop);
  assign acc         = in_ch.valid && in_ch.ready;

  assign out_ch.valid          = fill_q != 2'd0;
  assign out_ch.token_kind     = buf_q[0].kind;
  assign out_ch.at_line_start  = buf_q[0].line_start;
  assign out_ch.after_space    = buf_q[0].after_space;
  assign out_ch.start_location = buf_q[0].start;
  assign out_ch.token_length   = buf_q[0].length;
  assign out_ch.last_of_step   = buf_q[0].last;

  // Hold scan state and advance on each accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0; mode_q <= M_IDLE; pend_q <= 2'b11; tfl_q <= '0; off_q <= '0;
      tst_q <= '0; cnt_q <= '0; rdx_q <= RADIX_DEC; qk_q <= 1'b0; lbb_q <= 1'b0;
    end else begin
      if (cfg_we_i) base_q <= cfg_wdata_i;
      if (acc) begin
        mode_q <= mode_d; pend_q <= pend_d; tfl_q <= tfl_d; off_q <= off_d;
        tst_q <= tst_d; cnt_q <= cnt_d; rdx_q <= rdx_d; qk_q <= qk_d; lbb_q <= lbb_d;
      end
    end
  end

  // Queue tokens; drop the head on each delivered beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      if (acc) begin
        fill_q <= nt;
        buf_q[0] <= tok0;
        buf_q[1] <= tok1;
        if (fill_q == 2'd1 && !pop) fill_q <= fill_q;
      end else if (pop) begin
        fill_q <= fill_q - 2'd1;
        buf_q[0] <= buf_q[1];
      end
    end
  end

  `SBT_ASSERT(a_fill_max, clk_i, rst_ni, fill_q != 2'd3, "buffer overfilled")
  `SBT_ASSERT_NEXT(a_eof_out, clk_i, rst_ni, acc && in_ch.end_of_input,
    out_ch.valid, "end mark gave no token")
  `SBT_ASSERT(a_ready_empty, clk_i, rst_ni, !(fill_q == 2'd2 && in_ch.ready),
    "accepted while buffer full")
endmodule
